[rtl/pbsl_pkg.sv]
// shared types and constants for the particle bounds and speed limit unit
`timescale 1ns / 1ps
package pbsl_pkg;
	localparam int FRAC_BITS = 8;
	localparam int DW = 24;
	localparam int CFG_W = 16;
	localparam int DIM_W = 12;
	localparam int COEF_W = 16;
	localparam int LIM = 100 << FRAC_BITS;
	localparam int LIM_W = $clog2(LIM + 1);
	localparam int NUM_W = DW + LIM_W;
	localparam int SQ_W = 2 * DW;
	localparam int ROOT_W = DW;
	localparam int REM_W = DW + 2;
	localparam int SQRT_CELLS = ROOT_W;
	localparam int DIV_CELLS = LIM_W;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BOUNCE       = 2'd2;
	localparam logic [1:0] REG_GROUND       = 2'd3;

	typedef struct packed {
		logic signed [DW-1:0] px;
		logic signed [DW-1:0] py;
		logic signed [DW-1:0] vx;
		logic signed [DW-1:0] vy;
		logic                 big;
		logic [NUM_W-1:0]     nx;
		logic [NUM_W-1:0]     ny;
	} side_t;
endpackage

[rtl/pbsl_front.sv]
// clamp, bounce, deadzone and squared speed pipeline
`timescale 1ns / 1ps
module pbsl_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_i,
	input  logic [pbsl_pkg::DW-1:0]        pos_x,
	input  logic [pbsl_pkg::DW-1:0]        pos_y,
	input  logic [pbsl_pkg::DW-1:0]        vel_x,
	input  logic [pbsl_pkg::DW-1:0]        vel_y,
	input  logic [pbsl_pkg::DIM_W-1:0]     frame_width,
	input  logic [pbsl_pkg::DIM_W-1:0]     frame_height,
	input  logic [pbsl_pkg::COEF_W-1:0]    wall_coef,
	input  logic [pbsl_pkg::COEF_W-1:0]    floor_coef,
	output logic                           vld_o,
	output logic [pbsl_pkg::SQ_W-1:0]      rad_o,
	output pbsl_pkg::side_t                side_o
);
	import pbsl_pkg::*;

	localparam logic signed [59:0] MAXV = (60'sd1 <<< (DW - 1)) - 60'sd1;
	localparam logic signed [59:0] MINV = -(60'sd1 <<< (DW - 1));
	localparam logic signed [DW-1:0] DEADS = 24'sd1 <<< (FRAC_BITS - 2);
	localparam logic [LIM_W-1:0] LIM_U = LIM_W'(LIM);
	localparam logic [SQ_W-1:0] LIM2 = SQ_W'(LIM) * SQ_W'(LIM);

	function automatic logic signed [DW-1:0] neg_round(input logic signed [58:0] p,
			input logic [5:0] sh);
		logic signed [59:0] t;
		begin
			t = -$signed({p[58], p}) + (60'sd1 <<< (sh - 6'd1));
			t = t >>> sh;
			if (t > MAXV) t = MAXV;
			if (t < MINV) t = MINV;
			return t[DW-1:0];
		end
	endfunction

	logic signed [DW:0] wall, floor_y, near_y, px_w, py_w;
	logic hx_hi, hx_lo, hy_hi, hy_lo;
	logic signed [DW-1:0] px_c, py_c;

	assign wall = $signed({{(DW + 1 - DIM_W - FRAC_BITS){1'b0}}, frame_width,
		{FRAC_BITS{1'b0}}});
	assign floor_y = ($signed({{(DW + 1 - DIM_W){1'b0}}, frame_height}) - 25'sd10)
		<<< FRAC_BITS;
	assign near_y = ($signed({{(DW + 1 - DIM_W){1'b0}}, frame_height}) - 25'sd13)
		<<< FRAC_BITS;
	assign px_w = $signed({pos_x[DW-1], pos_x});
	assign py_w = $signed({pos_y[DW-1], pos_y});
	assign hx_hi = px_w > wall;
	assign hx_lo = pos_x[DW-1];
	assign hy_hi = py_w > floor_y;
	assign hy_lo = hy_hi ? floor_y[DW] : pos_y[DW-1];

	always_comb begin
		if (hx_hi) px_c = wall[DW-1:0];
		else if (hx_lo) px_c = '0;
		else px_c = $signed(pos_x);
		if (hy_lo) py_c = '0;
		else if (hy_hi) py_c = floor_y[DW-1:0];
		else py_c = $signed(pos_y);
	end

	logic [7:0] vld_q;
	logic signed [DW-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic hx_s1, hyf_s1, hyw_s1;
	logic signed [DW-1:0] px_s2, py_s2, vx_s2, vy_s2;
	logic hx_s2, hyf_s2, hyw_s2;
	logic signed [40:0] my1_s2;
	logic signed [DW-1:0] px_s3, py_s3, vx_s3, vy_s3;
	logic hx_s3, hyf_s3, hyw_s3;
	logic signed [57:0] my2_s3;
	logic signed [DW-1:0] px_s4, py_s4, vx_s4, vy_s4;
	logic hx_s4, hyw_s4;
	logic signed [DW-1:0] px_s5, py_s5, vx_s5, vy_s5;
	logic hx_s5, hyw_s5;
	logic signed [40:0] mx_s5, my_s5;
	logic signed [DW-1:0] px_s6, py_s6, vx_s6, vy_s6;
	logic signed [DW-1:0] px_s7, py_s7, vx_s7, vy_s7;
	logic [SQ_W-1:0] sqx_s7, sqy_s7;
	logic [NUM_W-1:0] nx_s7, ny_s7;
	logic signed [DW-1:0] wx, wy, dx, dy;
	logic [DW-1:0] ax, ay;
	logic [SQ_W-1:0] s_sum;

	always_comb begin
		wx = hx_s5 ? neg_round({{18{mx_s5[40]}}, mx_s5}, 6'd14) : vx_s5;
		wy = hyw_s5 ? neg_round({{18{my_s5[40]}}, my_s5}, 6'd14) : vy_s5;
		dx = (wx > -DEADS && wx < DEADS) ? '0 : wx;
		dy = (wy > -DEADS && wy < DEADS && $signed({py_s5[DW-1], py_s5}) > near_y)
			? '0 : wy;
		ax = vx_s6[DW-1] ? DW'(-vx_s6) : DW'(vx_s6);
		ay = vy_s6[DW-1] ? DW'(-vy_s6) : DW'(vy_s6);
		s_sum = sqx_s7 + sqy_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_c; py_s1 <= py_c;
			vx_s1 <= $signed(vel_x); vy_s1 <= $signed(vel_y);
			hx_s1 <= hx_hi | hx_lo; hyf_s1 <= hy_hi; hyw_s1 <= hy_lo;

			px_s2 <= px_s1; py_s2 <= py_s1; vx_s2 <= vx_s1; vy_s2 <= vy_s1;
			hx_s2 <= hx_s1; hyf_s2 <= hyf_s1; hyw_s2 <= hyw_s1;
			my1_s2 <= vy_s1 * $signed({1'b0, wall_coef});

			px_s3 <= px_s2; py_s3 <= py_s2; vx_s3 <= vx_s2; vy_s3 <= vy_s2;
			hx_s3 <= hx_s2; hyf_s3 <= hyf_s2; hyw_s3 <= hyw_s2;
			my2_s3 <= my1_s2 * $signed({1'b0, floor_coef});

			px_s4 <= px_s3; py_s4 <= py_s3; vx_s4 <= vx_s3;
			vy_s4 <= hyf_s3 ? neg_round({my2_s3[57], my2_s3}, 6'd28) : vy_s3;
			hx_s4 <= hx_s3; hyw_s4 <= hyw_s3;

			px_s5 <= px_s4; py_s5 <= py_s4; vx_s5 <= vx_s4; vy_s5 <= vy_s4;
			hx_s5 <= hx_s4; hyw_s5 <= hyw_s4;
			mx_s5 <= vx_s4 * $signed({1'b0, wall_coef});
			my_s5 <= vy_s4 * $signed({1'b0, wall_coef});

			px_s6 <= px_s5; py_s6 <= py_s5; vx_s6 <= dx; vy_s6 <= dy;

			px_s7 <= px_s6; py_s7 <= py_s6; vx_s7 <= vx_s6; vy_s7 <= vy_s6;
			sqx_s7 <= SQ_W'(vx_s6 * vx_s6);
			sqy_s7 <= SQ_W'(vy_s6 * vy_s6);
			nx_s7 <= NUM_W'(ax) * NUM_W'(LIM_U);
			ny_s7 <= NUM_W'(ay) * NUM_W'(LIM_U);

			rad_o <= s_sum;
			side_o.px <= px_s7; side_o.py <= py_s7;
			side_o.vx <= vx_s7; side_o.vy <= vy_s7;
			side_o.big <= s_sum > LIM2;
			side_o.nx <= nx_s7; side_o.ny <= ny_s7;
		end
	end

	assign vld_o = vld_q[7];
endmodule

[rtl/pbsl_sqrt_cell.sv]
// one digit cell of the pipelined integer square root
`timescale 1ns / 1ps
module pbsl_sqrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [pbsl_pkg::SQ_W-1:0]     rad_i,
	input  logic [pbsl_pkg::REM_W-1:0]    rem_i,
	input  logic [pbsl_pkg::ROOT_W-1:0]   root_i,
	input  pbsl_pkg::side_t               side_i,
	output logic                          vld_o,
	output logic [pbsl_pkg::SQ_W-1:0]     rad_o,
	output logic [pbsl_pkg::REM_W-1:0]    rem_o,
	output logic [pbsl_pkg::ROOT_W-1:0]   root_o,
	output pbsl_pkg::side_t               side_o
);
	import pbsl_pkg::*;

	logic [REM_W+1:0] cur, trial, diff;
	logic ge;

	assign cur = {rem_i, rad_i[SQ_W-1 -: 2]};
	assign trial = {{(REM_W - ROOT_W){1'b0}}, root_i, 2'b01};
	assign ge = cur >= trial;
	assign diff = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= {rad_i[SQ_W-3:0], 2'b00};
			rem_o <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
			root_o <= {root_i[ROOT_W-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule

[rtl/pbsl_div_cell.sv]
// one quotient bit cell of the two-lane speed scaling divider
`timescale 1ns / 1ps
module pbsl_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [pbsl_pkg::ROOT_W-1:0]   den_i,
	input  logic [pbsl_pkg::ROOT_W-1:0]   remx_i,
	input  logic [pbsl_pkg::ROOT_W-1:0]   remy_i,
	input  logic [pbsl_pkg::LIM_W-1:0]    lox_i,
	input  logic [pbsl_pkg::LIM_W-1:0]    loy_i,
	input  logic [pbsl_pkg::LIM_W-1:0]    qx_i,
	input  logic [pbsl_pkg::LIM_W-1:0]    qy_i,
	input  pbsl_pkg::side_t               side_i,
	output logic                          vld_o,
	output logic [pbsl_pkg::ROOT_W-1:0]   den_o,
	output logic [pbsl_pkg::ROOT_W-1:0]   remx_o,
	output logic [pbsl_pkg::ROOT_W-1:0]   remy_o,
	output logic [pbsl_pkg::LIM_W-1:0]    lox_o,
	output logic [pbsl_pkg::LIM_W-1:0]    loy_o,
	output logic [pbsl_pkg::LIM_W-1:0]    qx_o,
	output logic [pbsl_pkg::LIM_W-1:0]    qy_o,
	output pbsl_pkg::side_t               side_o
);
	import pbsl_pkg::*;

	logic [ROOT_W:0] cx, cy, dn, dfx, dfy;
	logic gex, gey;

	assign cx = {remx_i, lox_i[LIM_W-1]};
	assign cy = {remy_i, loy_i[LIM_W-1]};
	assign dn = {1'b0, den_i};
	assign gex = cx >= dn;
	assign gey = cy >= dn;
	assign dfx = cx - dn;
	assign dfy = cy - dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			remx_o <= gex ? dfx[ROOT_W-1:0] : cx[ROOT_W-1:0];
			remy_o <= gey ? dfy[ROOT_W-1:0] : cy[ROOT_W-1:0];
			lox_o <= {lox_i[LIM_W-2:0], 1'b0};
			loy_o <= {loy_i[LIM_W-2:0], 1'b0};
			qx_o <= {qx_i[LIM_W-2:0], gex};
			qy_o <= {qy_i[LIM_W-2:0], gey};
			side_o <= side_i;
		end
	end
endmodule

[rtl/particle_bounds_and_speed_limit_unit.sv]
// top level of the particle bounds and speed limit unit
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   pos_x, pos_y, vel_x, vel_y
// m_axis    out        m_axis_tvalid/m_axis_tready   new_pos_x, new_pos_y, new_vel_x, new_vel_y
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// one particle per cycle while the output is not held; 8 front stages, 24 square root cells,
// 15 divider cells and the output register
// the whole pipeline advances together; it holds while the output register is
// full and not taken, so input is taken whenever the output is free or drains
// reset clears the valid chain and loads the default register values
// cfg_ready is always high
`timescale 1ns / 1ps
module particle_bounds_and_speed_limit_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [95:0]                 s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [95:0]                 m_axis_tdata,  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [pbsl_pkg::CFG_W-1:0]  cfg_data
);
	import pbsl_pkg::*;

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [COEF_W-1:0] bounce_q, ground_q;
	logic en;
	logic out_vld_q;
	logic [95:0] out_data_q;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= DIM_W'(1024);
			frame_height_q <= DIM_W'(768);
			bounce_q <= COEF_W'(8192);
			ground_q <= COEF_W'(16384);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				REG_BOUNCE: bounce_q <= cfg_data[COEF_W-1:0];
				REG_GROUND: ground_q <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	logic sq_vld [0:SQRT_CELLS];
	logic [SQ_W-1:0] sq_rad [0:SQRT_CELLS];
	logic [REM_W-1:0] sq_rem [0:SQRT_CELLS];
	logic [ROOT_W-1:0] sq_root [0:SQRT_CELLS];
	side_t sq_side [0:SQRT_CELLS];

	pbsl_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(s_axis_tvalid),
		.pos_x(s_axis_tdata[23:0]), .pos_y(s_axis_tdata[47:24]),
		.vel_x(s_axis_tdata[71:48]), .vel_y(s_axis_tdata[95:72]),
		.frame_width(frame_width_q), .frame_height(frame_height_q),
		.wall_coef(bounce_q), .floor_coef(ground_q),
		.vld_o(sq_vld[0]), .rad_o(sq_rad[0]), .side_o(sq_side[0])
	);

	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;

	genvar i;
	generate
		for (i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
			pbsl_sqrt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(sq_vld[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
				.root_i(sq_root[i]), .side_i(sq_side[i]),
				.vld_o(sq_vld[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
				.root_o(sq_root[i+1]), .side_o(sq_side[i+1])
			);
		end
	endgenerate

	logic dv_vld [0:DIV_CELLS];
	logic [ROOT_W-1:0] dv_den [0:DIV_CELLS];
	logic [ROOT_W-1:0] dv_remx [0:DIV_CELLS];
	logic [ROOT_W-1:0] dv_remy [0:DIV_CELLS];
	logic [LIM_W-1:0] dv_lox [0:DIV_CELLS];
	logic [LIM_W-1:0] dv_loy [0:DIV_CELLS];
	logic [LIM_W-1:0] dv_qx [0:DIV_CELLS];
	logic [LIM_W-1:0] dv_qy [0:DIV_CELLS];
	side_t dv_side [0:DIV_CELLS];

	assign dv_vld[0] = sq_vld[SQRT_CELLS];
	assign dv_den[0] = sq_root[SQRT_CELLS];
	assign dv_remx[0] = sq_side[SQRT_CELLS].nx[NUM_W-1 -: ROOT_W];
	assign dv_remy[0] = sq_side[SQRT_CELLS].ny[NUM_W-1 -: ROOT_W];
	assign dv_lox[0] = sq_side[SQRT_CELLS].nx[LIM_W-1:0];
	assign dv_loy[0] = sq_side[SQRT_CELLS].ny[LIM_W-1:0];
	assign dv_qx[0] = '0;
	assign dv_qy[0] = '0;
	assign dv_side[0] = sq_side[SQRT_CELLS];

	generate
		for (i = 0; i < DIV_CELLS; i++) begin : g_div
			pbsl_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vld_i(dv_vld[i]), .den_i(dv_den[i]),
				.remx_i(dv_remx[i]), .remy_i(dv_remy[i]),
				.lox_i(dv_lox[i]), .loy_i(dv_loy[i]),
				.qx_i(dv_qx[i]), .qy_i(dv_qy[i]), .side_i(dv_side[i]),
				.vld_o(dv_vld[i+1]), .den_o(dv_den[i+1]),
				.remx_o(dv_remx[i+1]), .remy_o(dv_remy[i+1]),
				.lox_o(dv_lox[i+1]), .loy_o(dv_loy[i+1]),
				.qx_o(dv_qx[i+1]), .qy_o(dv_qy[i+1]), .side_o(dv_side[i+1])
			);
		end
	endgenerate

	side_t fin;
	logic [DW-1:0] qxe, qye, fvx, fvy;

	always_comb begin
		fin = dv_side[DIV_CELLS];
		qxe = DW'(dv_qx[DIV_CELLS]);
		qye = DW'(dv_qy[DIV_CELLS]);
		if (fin.big) begin
			fvx = fin.vx[DW-1] ? -qxe : qxe;
			fvy = fin.vy[DW-1] ? -qye : qye;
		end else begin
			fvx = fin.vx;
			fvy = fin.vy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {fvy, fvx, fin.py, fin.px};
		end
	end
endmodule
